// ===== rtl/core/khs_pkg.sv =====
package khs_pkg;

   // hash constants
   localparam logic [31:0] HASH_MUL   = 32'hc6a4a793;
   localparam int          WORD_SHIFT = 16;
   localparam int          TAIL_SHIFT = 24;

   // field widths
   localparam int BYTE_W       = 8;
   localparam int LEN_W        = 16;
   localparam int HASH_W       = 32;
   localparam int SHARD_W      = 16;
   localparam int SHARD_BITS_W = 5;

   // byte counter saturates at the longest key
   localparam int MAX_KEY_BYTES = 65535;
   localparam int COUNT_W       = $clog2(MAX_KEY_BYTES + 1);
   localparam int CMP_W         = (COUNT_W > LEN_W) ? COUNT_W : LEN_W;

   // op queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register map
   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_HASH_SEED  = 1'b0;
   localparam csr_index_type CSR_SHARD_BITS = 1'b1;

   // one unit of work for the back end
   typedef struct packed {
      logic               empty;   // zero-length key, result is the seed
      logic               start;   // seed the running hash from len
      logic [LEN_W-1:0]   len;
      logic               mix;     // add data, multiply, fold
      logic               tail;    // fold with the tail shift
      logic [HASH_W-1:0]  data;
      logic               emit;    // deliver the hash after this op
      logic               err;
   } khs_op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } khs_queue_status_type;

endpackage

// ===== rtl/core/khs_if.sv =====
interface khs_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic [15:0] key_length;
   logic        last_byte;

   modport source (output valid, data_byte, key_length, last_byte, input ready);
   modport sink   (input valid, data_byte, key_length, last_byte, output ready);
endinterface

interface khs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] hash_value;
   logic [15:0] shard_index;
   logic        length_error;

   modport source (output valid, hash_value, shard_index, length_error, input ready);
   modport sink   (input valid, hash_value, shard_index, length_error, output ready);
endinterface

interface khs_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/khs_queue.sv =====
module khs_queue
   import khs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  khs_op_type           push_op,
   input  logic                 pop,
   output khs_op_type           pop_op,
   output khs_queue_status_type status
);

   khs_op_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_op       = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full && !pop))
      else $error("op queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty))
      else $error("op queue underflow");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("op queue count out of range");

endmodule

// ===== rtl/core/khs_front.sv =====
module khs_front
   import khs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   khs_req_if.sink              req_if,
   input  khs_queue_status_type status,
   output logic                 push,
   output khs_op_type           push_op
);

   logic               key_started_ff, key_started_in;
   logic [LEN_W-1:0]   stated_len_ff, stated_len_in;
   logic [COUNT_W-1:0] seen_ff, seen_in;
   logic               over_ff, over_in;
   logic [1:0]         phase_ff, phase_in;
   logic [23:0]        pend_ff, pend_in;

   logic               accept;
   logic [COUNT_W-1:0] seen_base;
   logic               over_base;
   logic [1:0]         phase_base;
   logic [23:0]        pend_base;

   assign req_if.ready = !status.full;
   assign accept       = req_if.valid && req_if.ready;

   // classify each byte: start, word, tail, end of key
   always_comb begin
      key_started_in = key_started_ff;
      stated_len_in  = stated_len_ff;
      seen_in        = seen_ff;
      over_in        = over_ff;
      phase_in       = phase_ff;
      pend_in        = pend_ff;
      push           = 1'b0;
      push_op        = '0;

      // a new key restarts the byte bookkeeping
      seen_base  = key_started_ff ? seen_ff  : '0;
      over_base  = key_started_ff ? over_ff  : 1'b0;
      phase_base = key_started_ff ? phase_ff : 2'd0;
      pend_base  = key_started_ff ? pend_ff  : 24'd0;

      if (accept) begin
         if (!key_started_ff && (req_if.key_length == '0)) begin
            // zero-length key: one item, byte ignored
            push          = 1'b1;
            push_op.empty = 1'b1;
            push_op.emit  = 1'b1;
         end else begin
            if (!key_started_ff) begin
               push_op.start = 1'b1;
               push_op.len   = req_if.key_length;
               stated_len_in = req_if.key_length;
            end
            key_started_in = 1'b1;

            // saturating byte count
            if (seen_base >= COUNT_W'(MAX_KEY_BYTES)) begin
               over_in = 1'b1;
               seen_in = seen_base;
            end else begin
               over_in = over_base;
               seen_in = seen_base + 1'b1;
            end

            // pack bytes little-endian
            pend_in  = pend_base;
            phase_in = phase_base + 2'd1;
            case (phase_base)
               2'd0: begin
                  pend_in[7:0] = req_if.data_byte;
               end
               2'd1: begin
                  pend_in[15:8] = req_if.data_byte;
               end
               2'd2: begin
                  pend_in[23:16] = req_if.data_byte;
               end
               2'd3: begin
                  push_op.mix  = 1'b1;
                  push_op.data = {req_if.data_byte, pend_base};
                  pend_in      = '0;
               end
               default: begin
                  pend_in = pend_base;
               end
            endcase

            if (req_if.last_byte) begin
               if (phase_in != 2'd0) begin
                  push_op.mix  = 1'b1;
                  push_op.tail = 1'b1;
                  push_op.data = {8'd0, pend_in};
               end
               push_op.emit = 1'b1;
               push_op.err  = over_in ||
                              (CMP_W'(seen_in) != CMP_W'(stated_len_in));
               key_started_in = 1'b0;
               seen_in        = '0;
               over_in        = 1'b0;
               phase_in       = 2'd0;
               pend_in        = '0;
            end

            push = push_op.start || push_op.mix || push_op.emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_started_ff <= 1'b0;
         stated_len_ff  <= '0;
         seen_ff        <= '0;
         over_ff        <= 1'b0;
         phase_ff       <= 2'd0;
         pend_ff        <= '0;
      end else begin
         key_started_ff <= key_started_in;
         stated_len_ff  <= stated_len_in;
         seen_ff        <= seen_in;
         over_ff        <= over_in;
         phase_ff       <= phase_in;
         pend_ff        <= pend_in;
      end
   end

endmodule

// ===== rtl/core/khs_back.sv =====
module khs_back
   import khs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  khs_queue_status_type    status,
   output logic                    pop,
   input  khs_op_type              pop_op,
   input  logic [HASH_W-1:0]       hash_seed,
   input  logic [SHARD_BITS_W-1:0] shard_bits,
   khs_rsp_if.source               rsp_if
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_START = 7'b0000010,
      S_SEED  = 7'b0000100,
      S_ADD   = 7'b0001000,
      S_MUL   = 7'b0010000,
      S_FOLD  = 7'b0100000,
      S_EMIT  = 7'b1000000
   } back_state_type;

   back_state_type    state_ff, state_in;
   khs_op_type        op_ff, op_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [HASH_W-1:0] sum_ff, sum_in;
   logic [HASH_W-1:0] mul_ff, mul_in;
   logic [HASH_W-1:0] mul_a;
   logic [HASH_W-1:0] fold;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [HASH_W-1:0]  rsp_hash_ff, rsp_hash_in;
   logic [SHARD_W-1:0] rsp_shard_ff, rsp_shard_in;
   logic               rsp_err_ff, rsp_err_in;

   logic [SHARD_BITS_W-1:0] shard_sel;
   logic [SHARD_W:0]        shard_mask;
   logic                    out_free;

   // shared multiplier: key length at start, running sum otherwise
   assign mul_a  = (state_ff == S_START) ? HASH_W'(op_ff.len) : sum_ff;
   assign mul_in = mul_a * HASH_MUL;
   assign fold   = op_ff.tail ? (mul_ff ^ (mul_ff >> TAIL_SHIFT))
                              : (mul_ff ^ (mul_ff >> WORD_SHIFT));

   // shard mask, clamped at the index width
   assign shard_sel  = (shard_bits > SHARD_BITS_W'(SHARD_W)) ?
                       SHARD_BITS_W'(SHARD_W) : shard_bits;
   assign shard_mask = ((SHARD_W+1)'(1) << shard_sel) - (SHARD_W+1)'(1);

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // op sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      hash_in      = hash_ff;
      sum_in       = sum_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_hash_in  = rsp_hash_ff;
      rsp_shard_in = rsp_shard_ff;
      rsp_err_in   = rsp_err_ff;

      case (state_ff)
         S_IDLE: begin
            if (!status.empty) begin
               pop   = 1'b1;
               op_in = pop_op;
               if (pop_op.empty) begin
                  hash_in  = hash_seed;
                  state_in = S_EMIT;
               end else if (pop_op.start) begin
                  state_in = S_START;
               end else if (pop_op.mix) begin
                  state_in = S_ADD;
               end else if (pop_op.emit) begin
                  state_in = S_EMIT;
               end
            end
         end
         S_START: begin
            state_in = S_SEED;
         end
         S_SEED: begin
            hash_in = hash_seed ^ mul_ff;
            if (op_ff.mix) begin
               state_in = S_ADD;
            end else if (op_ff.emit) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ADD: begin
            sum_in   = hash_ff + op_ff.data;
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_FOLD;
         end
         S_FOLD: begin
            hash_in  = fold;
            state_in = op_ff.emit ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = hash_ff;
               rsp_shard_in = hash_ff[SHARD_W-1:0] & shard_mask[SHARD_W-1:0];
               rsp_err_in   = op_ff.err;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      hash_ff      <= hash_in;
      sum_ff       <= sum_in;
      mul_ff       <= mul_in;
      rsp_hash_ff  <= rsp_hash_in;
      rsp_shard_ff <= rsp_shard_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.hash_value   = rsp_hash_ff;
   assign rsp_if.shard_index  = rsp_shard_ff;
   assign rsp_if.length_error = rsp_err_ff;

endmodule

// ===== rtl/core/key_hash_shard_select.sv =====
// Streaming key hash with shard selection. Keys arrive one byte per item on
// req_if with the stated key length and a last-byte mark; each finished key
// yields one item on rsp_if with the 32-bit hash, its low shard_bits bits
// (clamped to 16) and a length error flag. The front end takes a byte every
// cycle while its four-entry op queue has room. The back end owns the single
// 32x32 multiplier: it pops an op while idle, then adds, multiplies and folds
// in the ADD, MUL and FOLD states; seeding a new key passes through the START
// and SEED states, and the EMIT state moves a result into the output register.
// Long keys sustain one byte per cycle while no result is held up by a stalled
// rsp_if. Queued ops and a stalled rsp_if delay a result. The output register
// holds a finished result while rsp_if stalls, and the back end keeps working
// until its next result is due. csr_if is always ready; index 0 writes
// hash_seed, index 1 writes shard_bits (reset 5); write only while idle.
module key_hash_shard_select
   import khs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   khs_req_if.sink    req_if,
   khs_rsp_if.source  rsp_if,
   khs_csr_if.sink    csr_if
);

   logic [HASH_W-1:0]       hash_seed_ff, hash_seed_in;
   logic [SHARD_BITS_W-1:0] shard_bits_ff, shard_bits_in;

   khs_queue_status_type status;
   logic                 push, pop;
   khs_op_type           push_op, pop_op;

   // configuration registers
   assign csr_if.ready = 1'b1;

   always_comb begin
      hash_seed_in  = hash_seed_ff;
      shard_bits_in = shard_bits_ff;
      if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            CSR_HASH_SEED: begin
               hash_seed_in = csr_if.data;
            end
            CSR_SHARD_BITS: begin
               shard_bits_in = csr_if.data[SHARD_BITS_W-1:0];
            end
            default: begin
               hash_seed_in = hash_seed_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_seed_ff  <= '0;
         shard_bits_ff <= SHARD_BITS_W'(5);
      end else begin
         hash_seed_ff  <= hash_seed_in;
         shard_bits_ff <= shard_bits_in;
      end
   end

   khs_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .status  (status),
      .push    (push),
      .push_op (push_op)
   );

   khs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .pop_op  (pop_op),
      .status  (status)
   );

   khs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .pop        (pop),
      .pop_op     (pop_op),
      .hash_seed  (hash_seed_ff),
      .shard_bits (shard_bits_ff),
      .rsp_if     (rsp_if)
   );

endmodule
